[rtl/bama_pkg.sv]
// Shared types and constants for the burst audio mix accumulator.
// No dependencies; every other file in rtl/ except bama_ram imports this package.
package bama_pkg;

  // Field widths of the item and result channels
  localparam int CMD_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int INDEX_W  = 10;
  localparam int MIX_W    = 24;
  localparam int CONS_W   = 11;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam int CPF_W     = 4;
  localparam int FPB_W     = 10;
  localparam int CFG_W     = 10;
  localparam logic [CPF_W-1:0] CPF_RESET = 4'd2;
  localparam logic [FPB_W-1:0] FPB_RESET = 10'd192;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 1'b1;

  // Defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int ACC_WIDTH_DEF   = 24;

  // Gain scaling: Q1.15 sample times Q2.14 gain, rounded back to 15 fraction bits
  localparam int GAIN_FRAC   = 14;
  localparam int ROUND_BIAS  = 1 << (GAIN_FRAC - 1);
  localparam int PROD_FULL_W = SAMPLE_W + GAIN_W + 1;
  localparam int PROD_W      = PROD_FULL_W - GAIN_FRAC;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_START  = 3'd1,
    CMD_SAMPLE = 3'd2,
    CMD_END    = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // Operation carried by the second stage
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    logic underflow;
    logic oob;
  } stage_ctrl_t;

  typedef struct packed {
    logic                     kind;
    logic signed [MIX_W-1:0]  mixed;
    logic                     underflow;
    logic        [CONS_W-1:0] consumed;
  } result_t;

endpackage

[rtl/bama_if.sv]
// Valid/ready channel interfaces for items and results.
// Depends on bama_pkg for field widths.
interface bama_in_if import bama_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [CMD_W-1:0]    command;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic        [GAIN_W-1:0]   gain;
  logic        [INDEX_W-1:0]  read_index;

  modport source (output valid, command, sample_value, gain, read_index, input ready);
  modport sink   (input valid, command, sample_value, gain, read_index, output ready);
endinterface

interface bama_out_if import bama_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [MIX_W-1:0]  mixed_value;
  logic                     underflow;
  logic        [CONS_W-1:0] consumed_samples;

  modport source (output valid, result_kind, mixed_value, underflow, consumed_samples,
                  input ready);
  modport sink   (input valid, result_kind, mixed_value, underflow, consumed_samples,
                  output ready);
endinterface

[rtl/bama_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bama_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bama_front.sv]
// Input stage: command decode, configuration, write position, gain and epoch state,
// gain multiply and RAM read address. Depends on bama_pkg and bama_if.
module bama_front import bama_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int AW = $clog2(MAX_SAMPLES),
  localparam int PW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  bama_in_if.sink                 items,
  input  logic                    hold,
  output logic [AW-1:0]           ram_raddr,
  output stage_ctrl_t             s1_ctrl,
  output logic [AW-1:0]           s1_addr,
  output logic signed [PROD_W-1:0] s1_prod,
  output logic [CONS_W-1:0]       s1_consumed,
  output logic                    current_epoch
);

  localparam int BL_W = CPF_W + FPB_W;

  logic [CPF_W-1:0]   channels_per_frame;
  logic [FPB_W-1:0]   frames_per_burst;
  logic [PW-1:0]      write_position;
  logic [GAIN_W-1:0]  client_gain;

  logic [BL_W-1:0]    blen_raw;
  logic [PW-1:0]      blen;
  logic               pos_ok;
  logic               accept;
  logic               oob;
  stage_ctrl_t        s1_ctrl_next;
  logic signed [PROD_FULL_W-1:0] prod_full;
  logic signed [PROD_FULL_W-1:0] prod_sum;

  assign items.ready = !hold;
  assign accept      = items.valid && items.ready;

  // Burst length, clamped to the buffer depth
  always_comb begin
    blen_raw = BL_W'(channels_per_frame) * BL_W'(frames_per_burst);
    if (32'(blen_raw) > 32'(MAX_SAMPLES)) begin
      blen = PW'(MAX_SAMPLES);
    end else begin
      blen = PW'(blen_raw);
    end
  end

  assign pos_ok = write_position < blen;
  assign oob    = 32'(items.read_index) >= 32'(MAX_SAMPLES);

  // Round half up to 15 fraction bits: add half an LSB, keep the high bits
  assign prod_full = PROD_FULL_W'(items.sample_value)
                   * PROD_FULL_W'(signed'({1'b0, client_gain}));
  assign prod_sum  = prod_full + PROD_FULL_W'(ROUND_BIAS);

  always_comb begin
    ram_raddr    = AW'(items.read_index);
    s1_ctrl_next = '0;
    s1_ctrl_next.oob       = oob;
    s1_ctrl_next.underflow = pos_ok;
    case (items.command)
      CMD_SAMPLE: begin
        ram_raddr          = AW'(write_position);
        s1_ctrl_next.valid = accept && pos_ok;
        s1_ctrl_next.op    = OP_WRITE;
      end
      CMD_END: begin
        s1_ctrl_next.valid = accept;
        s1_ctrl_next.op    = OP_REPORT;
      end
      CMD_READ: begin
        s1_ctrl_next.valid = accept;
        s1_ctrl_next.op    = OP_READ;
      end
      default: begin
        s1_ctrl_next.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_per_frame <= CPF_RESET;
      frames_per_burst   <= FPB_RESET;
      write_position     <= '0;
      client_gain        <= '0;
      current_epoch      <= 1'b1;
      s1_ctrl            <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CHANNELS: channels_per_frame <= cfg_data[CPF_W-1:0];
          REG_FRAMES:   frames_per_burst   <= cfg_data[FPB_W-1:0];
          default: ;
        endcase
      end
      s1_ctrl <= s1_ctrl_next;
      if (accept) begin
        case (items.command)
          CMD_CLEAR: current_epoch <= ~current_epoch;
          CMD_START: begin
            client_gain    <= items.gain;
            write_position <= '0;
          end
          CMD_SAMPLE: begin
            if (pos_ok) begin
              write_position <= write_position + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    s1_addr     <= ram_raddr;
    s1_prod     <= prod_sum[PROD_FULL_W-1:GAIN_FRAC];
    s1_consumed <= CONS_W'(write_position);
  end

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_position) <= 32'(MAX_SAMPLES))
    else $error("write position ran past the buffer depth");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (accept && items.command == CMD_SAMPLE && pos_ok)
      |=> (write_position == $past(write_position) + 1'b1))
    else $error("write position did not step after a mixed sample");
`endif

endmodule

[rtl/bama_back.sv]
// Mix stage: read-modify-write of the mix buffer with forwarding, saturating
// accumulate, result build and the clearing pass after reset. Depends on bama_pkg.
module bama_back import bama_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stage_ctrl_t              s1_ctrl,
  input  logic [AW-1:0]            s1_addr,
  input  logic signed [PROD_W-1:0] s1_prod,
  input  logic [CONS_W-1:0]        s1_consumed,
  input  logic                     current_epoch,
  input  logic [ACC_WIDTH:0]       ram_rdata,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [ACC_WIDTH:0]       ram_wdata,
  output logic                     clearing,
  output logic                     res_push,
  output result_t                  res_data
);

  localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
  localparam longint MAX_L = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam longint MIN_L = -MAX_L - 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(MAX_L);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(MIN_L);

  logic [AW-1:0]        clr_addr;
  logic                 fwd_valid;
  logic [AW-1:0]        fwd_addr;
  logic [ACC_WIDTH:0]   fwd_data;

  logic [ACC_WIDTH:0]           old_word;
  logic signed [ACC_WIDTH-1:0]  old_val;
  logic signed [ACC_WIDTH-1:0]  read_val;
  logic signed [SUM_W-1:0]      sum;
  logic signed [ACC_WIDTH-1:0]  new_val;
  logic                         do_write;

  // The entry written in the previous cycle is not yet in the read data
  assign old_word = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
  assign old_val  = (old_word[ACC_WIDTH] == current_epoch) ? old_word[ACC_WIDTH-1:0] : '0;
  assign read_val = s1_ctrl.oob ? '0 : old_val;

  always_comb begin
    sum = SUM_W'(old_val) + SUM_W'(s1_prod);
    if (sum > SAT_MAX) begin
      new_val = SAT_MAX[ACC_WIDTH-1:0];
    end else if (sum < SAT_MIN) begin
      new_val = SAT_MIN[ACC_WIDTH-1:0];
    end else begin
      new_val = sum[ACC_WIDTH-1:0];
    end
  end

  assign do_write  = s1_ctrl.valid && s1_ctrl.op == OP_WRITE;
  assign ram_we    = clearing || do_write;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : {current_epoch, new_val};

  always_comb begin
    res_push = s1_ctrl.valid && (s1_ctrl.op == OP_READ || s1_ctrl.op == OP_REPORT);
    res_data = '0;
    if (s1_ctrl.op == OP_READ) begin
      res_data.kind  = KIND_READ;
      res_data.mixed = MIX_W'(read_val);
    end else begin
      res_data.kind      = KIND_REPORT;
      res_data.underflow = s1_ctrl.underflow;
      res_data.consumed  = s1_consumed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= do_write;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(MAX_SAMPLES - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
    fwd_addr <= s1_addr;
    fwd_data <= {current_epoch, new_val};
  end

`ifndef NO_ASSERTIONS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_ctrl.valid)
    else $error("item reached the mix stage during the clearing pass");
`endif

endmodule

[rtl/bama_fifo.sv]
// Output queue of result items, registered, drives the result channel.
// Depends on bama_pkg and bama_if.
module bama_fifo import bama_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  result_t           push_data,
  output logic [QCNT_W-1:0] count,
  bama_out_if.source        results
);

  result_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic               pop;
  result_t            head;

  assign head                     = mem[rptr];
  assign results.valid            = count != '0;
  assign results.result_kind      = head.kind;
  assign results.mixed_value      = head.mixed;
  assign results.underflow        = head.underflow;
  assign results.consumed_samples = head.consumed;
  assign pop = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("output queue overflow");
`endif

endmodule

[rtl/burst_audio_mix_accumulator.sv]
// Burst audio mix accumulator: one item per cycle while ready is high; an accepted read or
// end-client item goes through the stage register and then the output queue to the result channel.
// Ready drops while the clearing pass runs or while the output queue backs up.
// Reset: config, position, gain and epoch return to defaults, then a clearing pass
// sweeps every entry of the mix RAM with ready low (config writes still taken).
// Depends on bama_pkg, bama_if, bama_ram, bama_front, bama_back and bama_fifo.
module burst_audio_mix_accumulator import bama_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bama_in_if.sink              items,
  bama_out_if.source           results
);

  localparam int AW = $clog2(MAX_SAMPLES);

  // Stage handoff between the input stage and the mix stage
  stage_ctrl_t               s1_ctrl;
  logic [AW-1:0]             s1_addr;
  logic signed [PROD_W-1:0]  s1_prod;
  logic [CONS_W-1:0]         s1_consumed;
  logic                      current_epoch;

  // Mix RAM: entry epoch bit on top of the accumulated value
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ACC_WIDTH:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ACC_WIDTH:0]   ram_rdata;

  logic                 clearing;
  logic                 res_push;
  result_t              res_data;
  logic [QCNT_W-1:0]    q_count;
  logic                 s1_has_result;
  logic                 hold;

  // Hold the input while the RAM is being swept, or when the queue count plus the result now in
  // the mix stage exceeds QDEPTH - 2, which keeps room for one from the item about to be accepted.
  assign s1_has_result = s1_ctrl.valid && s1_ctrl.op != OP_WRITE;
  assign hold = clearing
             || ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_has_result)
                 > (QCNT_W + 1)'(QDEPTH - 2));

  bama_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .items         (items),
    .hold          (hold),
    .ram_raddr     (ram_raddr),
    .s1_ctrl       (s1_ctrl),
    .s1_addr       (s1_addr),
    .s1_prod       (s1_prod),
    .s1_consumed   (s1_consumed),
    .current_epoch (current_epoch)
  );

  bama_ram #(
    .WIDTH (ACC_WIDTH + 1),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bama_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .s1_ctrl       (s1_ctrl),
    .s1_addr       (s1_addr),
    .s1_prod       (s1_prod),
    .s1_consumed   (s1_consumed),
    .current_epoch (current_epoch),
    .ram_rdata     (ram_rdata),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .clearing      (clearing),
    .res_push      (res_push),
    .res_data      (res_data)
  );

  bama_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .count     (q_count),
    .results   (results)
  );

`ifndef NO_ASSERTIONS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("result pushed into a full output queue");
`endif

endmodule

[sim/tb_burst_audio_mix_accumulator.sv]
// Self-checking testbench for the burst audio mix accumulator: directed and random items,
// a built-in predictor of the mix buffer and a result checker. Depends on rtl/ (bama_pkg,
// bama_if and the block itself).
module tb_burst_audio_mix_accumulator;
  import bama_pkg::*;

  // Command codes past the last defined command; the block ignores them
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'hffff;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h4000;
  localparam logic [GAIN_W-1:0] GAIN_HALF  = 16'h2000;

  localparam longint MIX_MAX = (longint'(1) << (MIX_W - 1)) - 1;
  localparam longint MIX_MIN = -MIX_MAX - 1;

  // A result passes the stage register and the output queue before it can be taken; leave some slack on top
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOT_ITEMS    = 360;
  // Clearing pass, ~1600 items with gaps and stalls, and config pauses fit well inside
  localparam int TIMEOUT_TU = 5_000_000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bama_in_if  items_if ();
  bama_out_if results_if ();

  burst_audio_mix_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the mix buffer, epochs and client context
  // ---------------------------------------------------------------------------
  logic signed [MIX_W-1:0] mix_mem [MAX_SAMPLES_DEF];
  bit                      epoch_mem [MAX_SAMPLES_DEF];
  // Entries touched by a sample since reset; the rest hold undefined data
  bit                      written_mem [MAX_SAMPLES_DEF];
  bit                      cur_epoch = 1'b1;
  int unsigned             write_pos = 0;
  logic [GAIN_W-1:0]       cur_gain  = '0;
  logic [CPF_W-1:0]        cfg_cpf   = CPF_RESET;
  logic [FPB_W-1:0]        cfg_fpb   = FPB_RESET;

  result_t mix_expected [$];
  int      mismatch_count = 0;
  int      items_sent     = 0;
  int      burst_left     = 8;

  function automatic int unsigned burst_len();
    int unsigned n;
    n = cfg_cpf * cfg_fpb;
    return (n > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : n;
  endfunction

  // A stale entry reads as zero
  function automatic longint entry_value(int idx);
    if (epoch_mem[idx] != cur_epoch) return 0;
    return longint'(mix_mem[idx]);
  endfunction

  // True when a read of this entry has a defined answer
  function automatic bit entry_defined(int idx);
    return written_mem[idx] || (epoch_mem[idx] != cur_epoch);
  endfunction

  // Apply one accepted item to the private state and queue the result it causes
  task automatic mix_predict(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] s,
                             logic [GAIN_W-1:0] g, logic [INDEX_W-1:0] ridx);
    int unsigned blen;
    longint      prod;
    longint      sum;
    result_t     r;
    blen = burst_len();
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        cur_epoch = ~cur_epoch;
      end
      CMD_START: begin
        cur_gain  = g;
        write_pos = 0;
      end
      CMD_SAMPLE: begin
        // Past the burst end the sample is dropped and the position holds
        if (write_pos < blen) begin
          // Q1.15 x Q2.14, round half up back to 15 fraction bits
          prod = (longint'(s) * longint'(cur_gain) + ROUND_BIAS) >>> GAIN_FRAC;
          sum  = entry_value(write_pos) + prod;
          if (sum > MIX_MAX) sum = MIX_MAX;
          else if (sum < MIX_MIN) sum = MIX_MIN;
          mix_mem[write_pos]     = sum[MIX_W-1:0];
          epoch_mem[write_pos]   = cur_epoch;
          written_mem[write_pos] = 1'b1;
          write_pos++;
        end
      end
      CMD_END: begin
        r.kind      = KIND_REPORT;
        r.underflow = (write_pos < blen);
        r.consumed  = CONS_W'(write_pos);
        mix_expected.push_back(r);
      end
      CMD_READ: begin
        r.kind  = KIND_READ;
        r.mixed = MIX_W'(entry_value(ridx));
        mix_expected.push_back(r);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per call, bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  // Call at a rising edge; returns at the edge that accepted the item, or after the gap that follows a burst.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] s,
                           logic [GAIN_W-1:0] g, logic [INDEX_W-1:0] ridx);
    bit found;
    int k;
    // Never read an entry whose contents are undefined; move to a defined one
    if (cmd == CMD_READ && !entry_defined(ridx)) begin
      found = 1'b0;
      for (k = 1; k < MAX_SAMPLES_DEF && !found; k++) begin
        if (entry_defined((ridx + k) % MAX_SAMPLES_DEF)) begin
          ridx  = INDEX_W'((ridx + k) % MAX_SAMPLES_DEF);
          found = 1'b1;
        end
      end
      if (!found) cmd = CMD_END;
    end
    items_if.valid        <= 1'b1;
    items_if.command      <= cmd;
    items_if.sample_value <= s;
    items_if.gain         <= g;
    items_if.read_index   <= ridx;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    mix_predict(cmd, s, g, ridx);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // Drop valid for a gap and scramble the idle payload
      items_if.valid        <= 1'b0;
      items_if.command      <= CMD_W'($urandom);
      items_if.sample_value <= SAMPLE_W'($urandom);
      items_if.gain         <= GAIN_W'($urandom);
      items_if.read_index   <= INDEX_W'($urandom);
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipeline drain
  task automatic wait_idle();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both burst registers back to back; call only while idle
  task automatic set_burst(logic [CPF_W-1:0] cpf, logic [FPB_W-1:0] fpb);
    cfg_write <= 1'b1;
    cfg_index <= REG_CHANNELS;
    cfg_data  <= CFG_W'(cpf);
    @(posedge clk);
    cfg_cpf = cpf;
    cfg_index <= REG_FRAMES;
    cfg_data  <= CFG_W'(fpb);
    @(posedge clk);
    cfg_fpb = fpb;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // sign_mode: 0 any value, 1 near positive full scale, 2 near negative full scale
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int sign_mode);
    case (sign_mode)
      1: return SAMPLE_W'($urandom_range(32000, 32767));
      2: return SAMPLE_W'(-int'($urandom_range(32000, 32768)));
      default: begin
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX
                                                                          : SAMPLE_MIN;
        return SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  // One well-formed client: start, n samples, end, then a few reads of the buffer
  task automatic mix_client(logic [GAIN_W-1:0] g, int n, int sign_mode, int reads);
    int          i;
    int unsigned blen;
    send_item(CMD_START, SAMPLE_W'($urandom), g, INDEX_W'($urandom));
    for (i = 0; i < n; i++)
      send_item(CMD_SAMPLE, pick_sample(sign_mode), GAIN_W'($urandom), INDEX_W'($urandom));
    send_item(CMD_END, SAMPLE_W'($urandom), GAIN_W'($urandom), INDEX_W'($urandom));
    blen = burst_len();
    for (i = 0; i < reads; i++) begin
      // Mostly inside the burst length, sometimes anywhere
      if ($urandom_range(0, 3) != 0 && blen != 0)
        send_item(CMD_READ, SAMPLE_W'($urandom), GAIN_W'($urandom),
                  INDEX_W'($urandom_range(0, blen - 1)));
      else
        send_item(CMD_READ, SAMPLE_W'($urandom), GAIN_W'($urandom),
                  INDEX_W'($urandom_range(0, MAX_SAMPLES_DEF - 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset state: empty buffer, zero position, zero gain, default burst of 384
  task automatic test_reset_defaults();
    logic [CMD_W-1:0] c;
    send_item(CMD_END, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, '0, '0, INDEX_W'(MAX_SAMPLES_DEF - 1));
    // Gain is still zero after reset, so this sample adds nothing
    send_item(CMD_SAMPLE, SAMPLE_MIN, GAIN_MAX, '0);
    send_item(CMD_END, '0, '0, '0);
    // Unused commands are dropped with no result
    for (c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI && c >= CMD_UNUSED_LO; c++)
      send_item(c, SAMPLE_W'($urandom), GAIN_W'($urandom), INDEX_W'($urandom));
  endtask

  // Field extremes, rounding, burst end, clears, zero and clamped burst length
  task automatic test_directed_cases();
    wait_idle();
    set_burst(4'd1, 10'd3);
    send_item(CMD_START, '0, GAIN_MAX, '0);
    send_item(CMD_SAMPLE, SAMPLE_MAX, '0, '0);
    send_item(CMD_SAMPLE, SAMPLE_MIN, '0, '0);
    send_item(CMD_SAMPLE, -16'sd1, '0, '0);
    // Past the burst end: ignored
    send_item(CMD_SAMPLE, 16'sd1, '0, '0);
    send_item(CMD_END, '0, '0, '0);
    send_item(CMD_READ, '0, '0, 10'd0);
    send_item(CMD_READ, '0, '0, 10'd1);
    send_item(CMD_READ, '0, '0, 10'd2);
    // Half gain on a one-LSB sample lands exactly on the rounding midpoint
    send_item(CMD_START, '0, GAIN_HALF, '0);
    send_item(CMD_SAMPLE, 16'sd1, '0, '0);
    send_item(CMD_END, '0, '0, '0);
    // One clear hides the buffer, a second brings old contents back
    send_item(CMD_CLEAR, '0, '0, '0);
    send_item(CMD_READ, '0, '0, 10'd0);
    send_item(CMD_CLEAR, '0, '0, '0);
    send_item(CMD_READ, '0, '0, 10'd0);

    // Zero burst length: every sample dropped, no underflow
    wait_idle();
    set_burst(4'd1, 10'd0);
    send_item(CMD_START, '0, GAIN_UNITY, '0);
    send_item(CMD_SAMPLE, SAMPLE_MAX, '0, '0);
    send_item(CMD_END, '0, '0, '0);

    // Largest setting: product clamped to the buffer depth
    wait_idle();
    set_burst(4'd8, 10'd512);
    send_item(CMD_START, '0, GAIN_UNITY, '0);
    send_item(CMD_SAMPLE, SAMPLE_MIN, '0, '0);
    send_item(CMD_END, '0, '0, '0);
    send_item(CMD_READ, '0, '0, INDEX_W'(MAX_SAMPLES_DEF - 1));
  endtask

  // Pile full-scale products onto one entry until it saturates, positive then negative
  task automatic test_saturation();
    int sign_mode;
    int stop_at;
    wait_idle();
    set_burst(4'd1, 10'd1);
    for (sign_mode = 1; sign_mode <= 2; sign_mode++) begin
      send_item(CMD_CLEAR, '0, '0, '0);
      stop_at = items_sent + HOT_ITEMS;
      while (items_sent < stop_at)
        mix_client(GAIN_W'($urandom_range(60000, 65535)), $urandom_range(1, 2), sign_mode, 1);
    end
  endtask

  // Phases of random settings; mostly well-formed clients, some noise items
  task automatic test_random_mix();
    int          stop_at;
    int          phase_end;
    int          n;
    int unsigned blen;
    logic [CPF_W-1:0] cpf;
    logic [FPB_W-1:0] fpb;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin cpf = 4'd8; fpb = 10'd512; end
        1: begin cpf = 4'd1; fpb = 10'd1; end
        2: begin
          if ($urandom_range(0, 1) != 0) begin cpf = 4'd0; fpb = FPB_W'($urandom_range(1, 512)); end
          else begin cpf = CPF_W'($urandom_range(1, 8)); fpb = 10'd0; end
        end
        3: begin cpf = CPF_W'($urandom_range(1, 8)); fpb = FPB_W'($urandom_range(1, 512)); end
        default: begin cpf = CPF_W'($urandom_range(1, 8)); fpb = FPB_W'($urandom_range(1, 8)); end
      endcase
      set_burst(cpf, fpb);
      blen = burst_len();
      phase_end = items_sent + $urandom_range(30, 90);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 6) != 0) begin
          // Aim at the burst size: exact fill, overrun or underflow
          if (blen > 48) n = $urandom_range(0, 40);
          else begin
            case ($urandom_range(0, 4))
              0: n = (blen == 0) ? 0 : $urandom_range(0, blen - 1);
              1: n = blen + $urandom_range(1, 3);
              default: n = blen;
            endcase
          end
          mix_client(GAIN_W'($urandom), n, 0, $urandom_range(0, 3));
        end else begin
          send_item(CMD_W'($urandom_range(CMD_CLEAR, CMD_UNUSED_HI)), SAMPLE_W'($urandom),
                    GAIN_W'($urandom), INDEX_W'($urandom_range(0, MAX_SAMPLES_DEF - 1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready on its own pattern of runs and stalls
  // ---------------------------------------------------------------------------
  initial begin
    int run_len;
    results_if.ready <= 1'b0;
    forever begin
      // Now and then hold ready high for a long stretch with no stall at all
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      repeat (run_len) begin
        @(posedge clk);
        results_if.ready <= 1'b1;
      end
      run_len = $urandom_range(1, 6);
      repeat (run_len) begin
        @(posedge clk);
        results_if.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (mix_expected.size() == 0) begin
        $display("%0t: unexpected result kind %0d mixed %h underflow %0d consumed %0d",
                 $time, results_if.result_kind, results_if.mixed_value,
                 results_if.underflow, results_if.consumed_samples);
        mismatch_count++;
      end else begin
        want = mix_expected.pop_front();
        if (results_if.result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d",
                   $time, want.kind, results_if.result_kind);
          mismatch_count++;
        end
        if (results_if.mixed_value !== want.mixed) begin
          $display("%0t: mixed_value expected %h actual %h",
                   $time, want.mixed, results_if.mixed_value);
          mismatch_count++;
        end
        if (results_if.underflow !== want.underflow) begin
          $display("%0t: underflow expected %0d actual %0d",
                   $time, want.underflow, results_if.underflow);
          mismatch_count++;
        end
        if (results_if.consumed_samples !== want.consumed) begin
          $display("%0t: consumed_samples expected %0d actual %0d",
                   $time, want.consumed, results_if.consumed_samples);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= REG_CHANNELS;
    cfg_data              <= '0;
    items_if.valid        <= 1'b0;
    items_if.command      <= CMD_CLEAR;
    items_if.sample_value <= '0;
    items_if.gain         <= '0;
    items_if.read_index   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The clearing pass after reset holds ready low; the sender just waits on it
    test_reset_defaults();
    test_directed_cases();
    test_saturation();
    test_random_mix();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_TU);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
